@@ src/msd_pkg.sv @@
`timescale 1ns / 1ps

package msd_pkg;

  // width of the window length register as seen on the configuration port
  localparam int LEN_BITS = 9;

  // window length after reset
  localparam int DEFAULT_WINDOW = 20;

  // default sizes handed down from the top level
  localparam int MAX_WINDOW_DEF  = 256;
  localparam int SAMPLE_BITS_DEF = 24;

  // quotient bits resolved per cycle by the shared divider
  localparam int DIV_STEP = 8;

endpackage

@@ src/msd_ram.sv @@
`timescale 1ns / 1ps

module msd_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // one write port, one registered read port
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

@@ src/msd_queue.sv @@
`timescale 1ns / 1ps

module msd_queue #(
  parameter int WIDTH = 8
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  logic [WIDTH-1:0] push_data,
  output logic             full,
  input  logic             pop,
  output logic             valid,
  output logic [WIDTH-1:0] head
);

  logic [WIDTH-1:0] ent_r [2];
  logic             wptr_r, wptr_nxt;
  logic             rptr_r, rptr_nxt;
  logic [1:0]       cnt_r, cnt_nxt;

  assign full  = (cnt_r == 2'd2);
  assign valid = (cnt_r != 2'd0);
  assign head  = ent_r[rptr_r];

  // pointer and occupancy update
  always_comb begin
    wptr_nxt = wptr_r;
    rptr_nxt = rptr_r;
    cnt_nxt  = cnt_r;
    if (push) begin
      wptr_nxt = ~wptr_r;
    end
    if (pop) begin
      rptr_nxt = ~rptr_r;
    end
    if (push && !pop) begin
      cnt_nxt = cnt_r + 2'd1;
    end else if (pop && !push) begin
      cnt_nxt = cnt_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wptr_r <= 1'b0;
      rptr_r <= 1'b0;
      cnt_r  <= 2'd0;
    end else begin
      wptr_r <= wptr_nxt;
      rptr_r <= rptr_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  // entry storage
  always_ff @(posedge clk) begin
    if (push) begin
      ent_r[wptr_r] <= push_data;
    end
  end

endmodule

@@ src/msd_front.sv @@
`timescale 1ns / 1ps

module msd_front import msd_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int NW   = $clog2(MAX_WINDOW + 1),
  localparam int SUMW = SAMPLE_BITS + NW,
  localparam int SQW  = 2 * SAMPLE_BITS + NW - 2,
  localparam int EW   = NW + SUMW + SQW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  input  logic                          cfg_valid,
  input  logic [LEN_BITS-1:0]           cfg_window_length,
  output logic                          push,
  output logic [EW-1:0]                 push_data,
  input  logic                          q_full
);

  localparam int AW   = $clog2(MAX_WINDOW);
  localparam int SQ1W = 2 * SAMPLE_BITS - 1;
  localparam int RESET_WINDOW = (DEFAULT_WINDOW > MAX_WINDOW) ? MAX_WINDOW : DEFAULT_WINDOW;

  typedef enum logic [3:0] {
    F_IDLE   = 4'b0001,
    F_SQNEW  = 4'b0010,
    F_SQOLD  = 4'b0100,
    F_UPDATE = 4'b1000
  } fstate_t;

  fstate_t                  state_r, state_nxt;
  logic [NW-1:0]            n_r, n_nxt;
  logic [NW-1:0]            fill_r, fill_nxt;
  logic [AW-1:0]            slot_r, slot_nxt;
  logic signed [SUMW-1:0]   sum_r, sum_nxt;
  logic [SQW-1:0]           sumsq_r, sumsq_nxt;
  logic signed [SAMPLE_BITS-1:0] x_r;
  logic [SQ1W-1:0]          xsq_r, oldsq_r;

  logic                          accept;
  logic [SAMPLE_BITS-1:0]        ring_rdata;
  logic signed [SAMPLE_BITS-1:0] old_sample;
  logic signed [SAMPLE_BITS-1:0] mul_in;
  logic signed [2*SAMPLE_BITS-1:0] mul_out;
  logic                          full;
  logic [NW-1:0]                 fill_inc;
  logic [NW-1:0]                 slot_inc;
  logic signed [SUMW-1:0]        x_ext, old_ext;
  logic [NW-1:0]                 n_cfg;
  logic                          ring_we;

  // take a sample only when idle and the queue can hold its request
  assign in_stall = !((state_r == F_IDLE) && !q_full);
  assign accept   = in_valid && !in_stall;

  // sample ring, read of the oldest entry starts with the accept
  msd_ram #(
    .WIDTH (SAMPLE_BITS),
    .DEPTH (MAX_WINDOW)
  ) u_ring (
    .clk   (clk),
    .we    (ring_we),
    .waddr (slot_r),
    .wdata (x_r),
    .re    (accept),
    .raddr (slot_r),
    .rdata (ring_rdata)
  );

  assign old_sample = $signed(ring_rdata);

  // one squarer shared by the new and the retiring sample
  assign mul_in  = (state_r == F_SQOLD) ? old_sample : x_r;
  assign mul_out = mul_in * mul_in;

  assign full     = (fill_r >= n_r);
  assign fill_inc = fill_r + NW'(1);
  assign slot_inc = NW'(slot_r) + NW'(1);
  assign x_ext    = {{(SUMW-SAMPLE_BITS){x_r[SAMPLE_BITS-1]}}, x_r};
  assign old_ext  = full ? {{(SUMW-SAMPLE_BITS){old_sample[SAMPLE_BITS-1]}}, old_sample}
                         : '0;
  assign ring_we  = (state_r == F_UPDATE);

  // clamp of a written window length
  always_comb begin
    if (cfg_window_length == '0) begin
      n_cfg = NW'(1);
    end else if (int'(cfg_window_length) > MAX_WINDOW) begin
      n_cfg = NW'(MAX_WINDOW);
    end else begin
      n_cfg = NW'(cfg_window_length);
    end
  end

  // running sums and fill control
  always_comb begin
    state_nxt = state_r;
    n_nxt     = n_r;
    fill_nxt  = fill_r;
    slot_nxt  = slot_r;
    sum_nxt   = sum_r;
    sumsq_nxt = sumsq_r;
    push      = 1'b0;
    case (state_r)
      F_IDLE: begin
        if (accept) begin
          state_nxt = F_SQNEW;
        end
      end
      F_SQNEW: begin
        state_nxt = F_SQOLD;
      end
      F_SQOLD: begin
        state_nxt = F_UPDATE;
      end
      F_UPDATE: begin
        sum_nxt   = sum_r + x_ext - old_ext;
        sumsq_nxt = sumsq_r + SQW'(xsq_r) - (full ? SQW'(oldsq_r) : '0);
        slot_nxt  = (slot_inc >= n_r) ? '0 : slot_inc[AW-1:0];
        fill_nxt  = full ? fill_r : fill_inc;
        push      = full || (fill_inc == n_r);
        state_nxt = F_IDLE;
      end
      default: begin
        state_nxt = F_IDLE;
      end
    endcase
    if (cfg_valid) begin
      n_nxt     = n_cfg;
      fill_nxt  = '0;
      slot_nxt  = '0;
      sum_nxt   = '0;
      sumsq_nxt = '0;
    end
  end

  assign push_data = {n_r, sum_nxt, sumsq_nxt};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= F_IDLE;
      n_r     <= NW'(RESET_WINDOW);
      fill_r  <= '0;
      slot_r  <= '0;
      sum_r   <= '0;
      sumsq_r <= '0;
    end else begin
      state_r <= state_nxt;
      n_r     <= n_nxt;
      fill_r  <= fill_nxt;
      slot_r  <= slot_nxt;
      sum_r   <= sum_nxt;
      sumsq_r <= sumsq_nxt;
    end
  end

  // sample and squares
  always_ff @(posedge clk) begin
    if (accept) begin
      x_r <= in_sample;
    end
    if (state_r == F_SQNEW) begin
      xsq_r <= mul_out[SQ1W-1:0];
    end
    if (state_r == F_SQOLD) begin
      oldsq_r <= mul_out[SQ1W-1:0];
    end
  end

endmodule

@@ src/msd_div.sv @@
`timescale 1ns / 1ps

module msd_div import msd_pkg::*; #(
  parameter int DW = 64,
  parameter int VW = 9
) (
  input  logic          clk,
  input  logic          rst_n,
  input  logic          start,
  input  logic [DW-1:0] dividend,
  input  logic [VW-1:0] divisor,
  output logic          busy,
  output logic          done,
  output logic [DW-1:0] quotient
);

  localparam int ITER = (DW + DIV_STEP - 1) / DIV_STEP;
  localparam int PW   = ITER * DIV_STEP;
  localparam int CW   = (ITER > 1) ? $clog2(ITER) : 1;

  logic [PW-1:0] sh_r;
  logic [VW-1:0] rem_r;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic          busy_r, busy_nxt;
  logic          done_r, done_nxt;

  logic [PW-1:0] s;
  logic [VW-1:0] r;
  logic [VW:0]   t;

  // restoring steps, quotient bits shift in behind the dividend bits
  always_comb begin
    s = sh_r;
    r = rem_r;
    t = '0;
    for (int i = 0; i < DIV_STEP; i++) begin
      t = {r, s[PW-1]};
      s = {s[PW-2:0], 1'b0};
      if (t >= {1'b0, divisor}) begin
        t    = t - {1'b0, divisor};
        s[0] = 1'b1;
      end
      r = t[VW-1:0];
    end
  end

  // iteration count
  always_comb begin
    busy_nxt = busy_r;
    cnt_nxt  = cnt_r;
    done_nxt = 1'b0;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = '0;
    end else if (busy_r) begin
      if (cnt_r == CW'(ITER - 1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end else begin
        cnt_nxt = cnt_r + CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (start) begin
      sh_r  <= PW'(dividend);
      rem_r <= '0;
    end else if (busy_r) begin
      sh_r  <= s;
      rem_r <= r;
    end
  end

  assign busy     = busy_r;
  assign done     = done_r;
  assign quotient = sh_r[DW-1:0];

endmodule

@@ src/msd_back.sv @@
`timescale 1ns / 1ps

module msd_back import msd_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF,
  localparam int NW   = $clog2(MAX_WINDOW + 1),
  localparam int SUMW = SAMPLE_BITS + NW,
  localparam int SQW  = 2 * SAMPLE_BITS + NW - 2,
  localparam int EW   = NW + SUMW + SQW
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          q_valid,
  input  logic [EW-1:0]                 q_head,
  output logic                          q_pop,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_mean,
  output logic [SAMPLE_BITS-2:0]        out_deviation
);

  localparam int SB   = SAMPLE_BITS;
  localparam int MW   = SUMW - 1;
  localparam int NUMW = 2 * MW;
  localparam int H    = (MW + 1) / 2;
  localparam int CMAX = (NW > SB) ? NW : SB;
  localparam int CNTW = $clog2(CMAX);

  typedef enum logic [10:0] {
    B_IDLE = 11'b000_0000_0001,
    B_NSQ  = 11'b000_0000_0010,
    B_SQ0  = 11'b000_0000_0100,
    B_SQ1  = 11'b000_0000_1000,
    B_SQ2  = 11'b000_0001_0000,
    B_SQ3  = 11'b000_0010_0000,
    B_SUB  = 11'b000_0100_0000,
    B_DIV1 = 11'b000_1000_0000,
    B_DIV2 = 11'b001_0000_0000,
    B_ROOT = 11'b010_0000_0000,
    B_DONE = 11'b100_0000_0000
  } bstate_t;

  bstate_t          state_r, state_nxt;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [NW-1:0]    n_r, nsh_r;
  logic [SQW-1:0]   sumsq_r;
  logic [MW-1:0]    mag_r;
  logic             neg_r;
  logic [NUMW-1:0]  acc_r, nsq_r;
  logic [2*H-1:0]   prod_r;
  logic [2*SB-1:0]  vsh_r;
  logic [SB:0]      rem_r;
  logic [SB-1:0]    root_r;
  logic signed [SB-1:0] out_mean_r;
  logic [SB-2:0]    out_dev_r;

  logic [NW-1:0]          q_n;
  logic signed [SUMW-1:0] q_sum, q_sum_abs;
  logic [SQW-1:0]         q_sumsq;
  logic [NUMW-1:0]        acc_nsq;
  logic [NUMW-1:0]        num;
  logic [H-1:0]           lo, hi, mul_a, mul_b;
  logic [2*H-1:0]         mul_p;
  logic [SB+2:0]          rr, tt;
  logic [SB:0]            rem_step;
  logic                   root_bit;
  logic                   out_load;
  logic                   div_start, div_busy, div_done;
  logic [NUMW-1:0]        div_dividend, div_quot;
  logic [SB-1:0]          mean_mag;

  // unpack a queued request
  assign q_n       = q_head[EW-1 -: NW];
  assign q_sum     = $signed(q_head[SQW +: SUMW]);
  assign q_sumsq   = q_head[SQW-1:0];
  assign q_sum_abs = q_sum[SUMW-1] ? -q_sum : q_sum;

  // n times sum of squares, msb-first shift and add
  assign acc_nsq = (acc_r << 1) + (nsh_r[NW-1] ? NUMW'(sumsq_r) : '0);

  // square of the sum from half-width partial products
  assign lo = mag_r[H-1:0];
  assign hi = H'(mag_r[MW-1:H]);
  always_comb begin
    mul_a = lo;
    mul_b = lo;
    if (state_r == B_SQ1) begin
      mul_b = hi;
    end else if (state_r == B_SQ2) begin
      mul_a = hi;
      mul_b = hi;
    end
  end
  assign mul_p = mul_a * mul_b;

  assign num = (nsq_r >= acc_r) ? (nsq_r - acc_r) : '0;

  // digit-by-digit square root step
  assign rr       = {rem_r, vsh_r[2*SB-1 -: 2]};
  assign tt       = {1'b0, root_r, 2'b01};
  assign root_bit = (rr >= tt);
  assign rem_step = root_bit ? (rr[SB:0] - tt[SB:0]) : rr[SB:0];

  // shared divider for both divisions by n and the mean
  msd_div #(
    .DW (NUMW),
    .VW (NW)
  ) u_div (
    .clk      (clk),
    .rst_n    (rst_n),
    .start    (div_start),
    .dividend (div_dividend),
    .divisor  (n_r),
    .busy     (div_busy),
    .done     (div_done),
    .quotient (div_quot)
  );

  // sequencer
  always_comb begin
    state_nxt    = state_r;
    cnt_nxt      = cnt_r;
    q_pop        = 1'b0;
    div_start    = 1'b0;
    div_dividend = num;
    out_load     = 1'b0;
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          q_pop     = 1'b1;
          cnt_nxt   = '0;
          state_nxt = B_NSQ;
        end
      end
      B_NSQ: begin
        if (cnt_r == CNTW'(NW - 1)) begin
          cnt_nxt   = '0;
          state_nxt = B_SQ0;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      B_SQ0: begin
        state_nxt = B_SQ1;
      end
      B_SQ1: begin
        state_nxt = B_SQ2;
      end
      B_SQ2: begin
        state_nxt = B_SQ3;
      end
      B_SQ3: begin
        state_nxt = B_SUB;
      end
      B_SUB: begin
        div_start = 1'b1;
        state_nxt = B_DIV1;
      end
      B_DIV1: begin
        div_dividend = div_quot;
        if (div_done) begin
          div_start = 1'b1;
          state_nxt = B_DIV2;
        end
      end
      B_DIV2: begin
        div_dividend = NUMW'(mag_r);
        if (div_done) begin
          div_start = 1'b1;
          cnt_nxt   = '0;
          state_nxt = B_ROOT;
        end
      end
      B_ROOT: begin
        if (cnt_r == CNTW'(SB - 1)) begin
          state_nxt = B_DONE;
        end else begin
          cnt_nxt = cnt_r + CNTW'(1);
        end
      end
      B_DONE: begin
        if (!div_busy && (!out_valid_r || !out_stall)) begin
          out_load  = 1'b1;
          state_nxt = B_IDLE;
        end
      end
      default: begin
        state_nxt = B_IDLE;
      end
    endcase
  end

  // output register holds until taken
  always_comb begin
    out_valid_nxt = out_valid_r;
    if (out_load) begin
      out_valid_nxt = 1'b1;
    end else if (!out_stall) begin
      out_valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= B_IDLE;
      cnt_r       <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r     <= state_nxt;
      cnt_r       <= cnt_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  // datapath registers
  always_ff @(posedge clk) begin
    case (state_r)
      B_IDLE: begin
        if (q_valid) begin
          n_r     <= q_n;
          nsh_r   <= q_n;
          sumsq_r <= q_sumsq;
          neg_r   <= q_sum[SUMW-1];
          mag_r   <= q_sum_abs[MW-1:0];
          acc_r   <= '0;
        end
      end
      B_NSQ: begin
        acc_r <= acc_nsq;
        nsh_r <= nsh_r << 1;
      end
      B_SQ0: begin
        nsq_r  <= acc_r;
        prod_r <= mul_p;
      end
      B_SQ1: begin
        acc_r  <= NUMW'(prod_r);
        prod_r <= mul_p;
      end
      B_SQ2: begin
        acc_r  <= acc_r + (NUMW'(prod_r) << (H + 1));
        prod_r <= mul_p;
      end
      B_SQ3: begin
        acc_r <= acc_r + (NUMW'(prod_r) << (2 * H));
      end
      B_DIV2: begin
        if (div_done) begin
          vsh_r  <= div_quot[2*SB-1:0];
          rem_r  <= '0;
          root_r <= '0;
        end
      end
      B_ROOT: begin
        vsh_r  <= vsh_r << 2;
        rem_r  <= rem_step;
        root_r <= {root_r[SB-2:0], root_bit};
      end
      default: begin
      end
    endcase
  end

  // mean sign and deviation clamp
  assign mean_mag = div_quot[SB-1:0];

  always_ff @(posedge clk) begin
    if (out_load) begin
      out_mean_r <= neg_r ? -$signed(mean_mag) : $signed(mean_mag);
      out_dev_r  <= root_r[SB-1] ? '1 : root_r[SB-2:0];
    end
  end

  assign out_valid       = out_valid_r;
  assign out_window_mean = out_mean_r;
  assign out_deviation   = out_dev_r;

endmodule

@@ src/moving_standard_deviation.sv @@
`timescale 1ns / 1ps

// Rolling mean and population standard deviation over the last N samples.
// in_*  : one signed Q12.12 sample per request, valid/stall handshake.
// out_* : window mean (signed Q12.12) and deviation (unsigned Q11.12), one
//         request per sample once N samples have arrived; earlier samples
//         give nothing.
// cfg_* : window length N, valid/ready, always ready; a write clamps N to
//         1..MAX_WINDOW and restarts the fill. Write only while idle.
// The front end handles one sample at a time (ring read, two squares
// through one multiplier, sum update). The back end takes a new request
// only once the last result is loaded; its time per result is set by the
// shared 8-bit-per-cycle divider, used for both divisions of the variance
// by n and for the mean, and by the one-bit-per-cycle square root.
// A two-entry queue between the two ends lets the front keep taking
// samples while the back works.
// Reset (rst_n low, synchronous) sets N to 20 and empties the window; the
// ring needs no clearing. A stalled result holds on the output register,
// the back end finishes the next result and waits, then the queue fills
// and in_stall rises.
module moving_standard_deviation import msd_pkg::*; #(
  parameter int MAX_WINDOW  = MAX_WINDOW_DEF,
  parameter int SAMPLE_BITS = SAMPLE_BITS_DEF
) (
  input  logic                          clk,
  input  logic                          rst_n,
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic signed [SAMPLE_BITS-1:0] in_sample,
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic signed [SAMPLE_BITS-1:0] out_window_mean,
  output logic [SAMPLE_BITS-2:0]        out_deviation,
  input  logic                          cfg_valid,
  output logic                          cfg_ready,
  input  logic [LEN_BITS-1:0]           cfg_window_length
);

  localparam int NW   = $clog2(MAX_WINDOW + 1);
  localparam int SUMW = SAMPLE_BITS + NW;
  localparam int SQW  = 2 * SAMPLE_BITS + NW - 2;
  localparam int EW   = NW + SUMW + SQW;

  logic          push, q_full, q_pop, q_valid;
  logic [EW-1:0] push_data, q_head;

  // register writes are taken at once
  assign cfg_ready = 1'b1;

  // sample ring and running sums
  msd_front #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_front (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (in_valid),
    .in_stall          (in_stall),
    .in_sample         (in_sample),
    .cfg_valid         (cfg_valid),
    .cfg_window_length (cfg_window_length),
    .push              (push),
    .push_data         (push_data),
    .q_full            (q_full)
  );

  // requests for the statistics back end
  msd_queue #(
    .WIDTH (EW)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_data (push_data),
    .full      (q_full),
    .pop       (q_pop),
    .valid     (q_valid),
    .head      (q_head)
  );

  // mean, variance and root
  msd_back #(
    .MAX_WINDOW  (MAX_WINDOW),
    .SAMPLE_BITS (SAMPLE_BITS)
  ) u_back (
    .clk             (clk),
    .rst_n           (rst_n),
    .q_valid         (q_valid),
    .q_head          (q_head),
    .q_pop           (q_pop),
    .out_valid       (out_valid),
    .out_stall       (out_stall),
    .out_window_mean (out_window_mean),
    .out_deviation   (out_deviation)
  );

endmodule
